@@ hdl/skvt_pkg.sv @@
// Shared types and constants for the sorted key/value table.
// No dependencies; compiled first.
`default_nettype none

package skvt_pkg;

  // field widths
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int ECNT_W  = 9;

  // default table depth
  localparam int DEF_CAPACITY = 256;

  // cells per first-level OR group in the hit reduction
  localparam int GRP_SIZE = 16;

  // operation codes
  localparam logic [FUNC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic cmp;  // compare the request key against the stored key
    logic ins;  // open a slot and load the new pair
    logic del;  // close the slot of the matched pair
    logic upd;  // overwrite the value of the matched pair
  } skvt_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/skvt_req_if.sv @@
// Request channel: one operation word (func, key, value) with valid/ready.
// Depends on skvt_pkg.
`default_nettype none

interface skvt_req_if
  import skvt_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [KEY_W-1:0]  key;
  logic [VAL_W-1:0]         value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/skvt_rsp_if.sv @@
// Response channel: one result word (status, found_value, entry_count).
// Depends on skvt_pkg.
`default_nettype none

interface skvt_rsp_if
  import skvt_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [VAL_W-1:0]   found_value;
  logic [ECNT_W-1:0]  entry_count;

  modport source (output valid, output status, output found_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found_value, input entry_count,
                  output ready);
endinterface

`default_nettype wire

@@ hdl/skvt_cell.sv @@
// One slot of the table: holds a key/value pair, compares it with the request
// and shifts with its neighbours on insert/delete. Depends on skvt_pkg.
`default_nettype none

module skvt_cell
  import skvt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int INDEX    = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  wire logic                    clk,
  input  wire skvt_ctrl_t              ctrl,
  input  wire logic [CW-1:0]           count,
  input  wire logic signed [KEY_W-1:0] req_key,
  input  wire logic [VAL_W-1:0]        req_value,
  // left neighbour (lower index)
  input  wire logic                    left_lt,
  input  wire logic [KEY_W-1:0]        left_key,
  input  wire logic [VAL_W-1:0]        left_value,
  // right neighbour (higher index)
  input  wire logic [KEY_W-1:0]        right_key,
  input  wire logic [VAL_W-1:0]        right_value,
  output logic [KEY_W-1:0]             key,
  output logic [VAL_W-1:0]             value,
  output logic                         lt,
  output logic                         eq,
  output logic [VAL_W-1:0]             hit_value
);

  logic slot_used;

  // slot holds a live pair when it lies below the fill count
  assign slot_used = CW'(INDEX) < count;

  // compare flags, captured once per operation
  always_ff @(posedge clk) begin
    if (ctrl.cmp) begin
      lt <= slot_used && ($signed(key) < req_key);
      eq <= slot_used && ($signed(key) == req_key);
    end
  end

  // value of this slot if it matched, else zero, for the OR reduction
  assign hit_value = eq ? value : '0;

  // shift / load
  always_ff @(posedge clk) begin
    if (ctrl.ins && !lt) begin
      if (left_lt) begin
        key   <= req_key;
        value <= req_value;
      end else begin
        key   <= left_key;
        value <= left_value;
      end
    end else if (ctrl.del && !lt) begin
      key   <= right_key;
      value <= right_value;
    end else if (ctrl.upd && eq) begin
      value <= req_value;
    end
  end

endmodule

`default_nettype wire

@@ hdl/skvt_reduce.sv @@
// Two-level registered OR tree that gathers the match flag and matched value
// from every cell. Depends on skvt_pkg.
`default_nettype none

module skvt_reduce
  import skvt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             eq   [CAPACITY],
  input  wire logic [VAL_W-1:0] hit  [CAPACITY],
  output logic                  found,
  output logic [VAL_W-1:0]      found_value
);

  localparam int NGRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  logic             grp_eq   [NGRP];
  logic [VAL_W-1:0] grp_hit  [NGRP];
  logic             grp_eq_c [NGRP];
  logic [VAL_W-1:0] grp_hit_c[NGRP];
  logic             all_eq_c;
  logic [VAL_W-1:0] all_hit_c;

  // first level: OR inside each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_eq_c[g]  = 1'b0;
      grp_hit_c[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (g * GRP_SIZE + j < CAPACITY) begin
          grp_eq_c[g]  = grp_eq_c[g]  | eq[g * GRP_SIZE + j];
          grp_hit_c[g] = grp_hit_c[g] | hit[g * GRP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_eq  <= grp_eq_c;
    grp_hit <= grp_hit_c;
  end

  // second level: OR across the groups
  always_comb begin
    all_eq_c  = 1'b0;
    all_hit_c = '0;
    for (int g = 0; g < NGRP; g++) begin
      all_eq_c  = all_eq_c  | grp_eq[g];
      all_hit_c = all_hit_c | grp_hit[g];
    end
  end

  always_ff @(posedge clk) begin
    found       <= all_eq_c;
    found_value <= all_hit_c;
  end

endmodule

`default_nettype wire

@@ hdl/sorted_key_value_table.sv @@
// Top level of the sorted key/value table: sequencer, cell chain and reduction.
// Depends on skvt_pkg, skvt_req_if, skvt_rsp_if, skvt_cell, skvt_reduce.
//
// Keeps up to CAPACITY pairs in ascending signed key order in a row of cells.
// One operation (insert/update, lookup, delete) is taken at a time and passes
// through these steps from acceptance to the result word appearing: a step in
// which every cell compares its key against the request, the steps through the
// registered first and second levels of the OR tree that gather the match and
// its value, and a final step in which the chain shifts or the matched value
// is overwritten. A new request is taken only after the final step; a result
// still waiting on the response side does not stop the next request from being
// accepted, only its final step. The tables need no clearing after reset: only
// slots below the fill count are ever looked at.
`default_nettype none

module sorted_key_value_table
  import skvt_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic    clk,
  input  wire logic    rst,
  skvt_req_if.sink     req,
  skvt_rsp_if.source   rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_GRP   = 5'b00100,
    S_FIN   = 5'b01000,
    S_APPLY = 5'b10000
  } state_t;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [FUNC_W-1:0]       op;
  logic signed [KEY_W-1:0] op_key;
  logic [VAL_W-1:0]        op_value;
  logic                    out_valid;
  logic [STAT_W-1:0]       out_status;
  logic [VAL_W-1:0]        out_value;
  logic [CW-1:0]           out_count;

  skvt_ctrl_t              ctrl;
  logic                    apply;
  logic                    found;
  logic [VAL_W-1:0]        found_value;
  logic [STAT_W-1:0]       status_c;
  logic [VAL_W-1:0]        value_c;

  logic [KEY_W-1:0]        cell_key  [CAPACITY];
  logic [VAL_W-1:0]        cell_value[CAPACITY];
  logic                    cell_lt   [CAPACITY];
  logic                    cell_eq   [CAPACITY];
  logic [VAL_W-1:0]        cell_hit  [CAPACITY];

  assign req.ready = (state == S_IDLE);

  // last step waits for the output register to be free
  assign apply = (state == S_APPLY) && (!out_valid || rsp.ready);

  // request capture
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op       <= req.func;
      op_key   <= req.key;
      op_value <= req.value;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req.valid) state_next = S_CMP;
      S_CMP:   state_next = S_GRP;
      S_GRP:   state_next = S_FIN;
      S_FIN:   state_next = S_APPLY;
      S_APPLY: if (apply) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // decision on the gathered match
  always_comb begin
    ctrl       = '0;
    ctrl.cmp   = (state == S_CMP);
    count_next = count;
    status_c   = ST_OK;
    value_c    = '0;
    case (op)
      OP_INSERT: begin
        if (found) begin
          ctrl.upd = apply;
        end else if (count == CW'(CAPACITY)) begin
          status_c = ST_FULL;
        end else begin
          ctrl.ins   = apply;
          count_next = count + 1'b1;
        end
      end
      OP_LOOKUP: begin
        if (found) value_c  = found_value;
        else       status_c = ST_NOT_FOUND;
      end
      OP_DELETE: begin
        if (found) begin
          ctrl.del   = apply;
          count_next = count - 1'b1;
        end else begin
          status_c = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (apply) begin
      out_status <= status_c;
      out_value  <= value_c;
      out_count  <= count_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_value = out_value;
  assign rsp.entry_count = ECNT_W'(out_count);

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             l_lt;
    logic [KEY_W-1:0] l_key;
    logic [VAL_W-1:0] l_value;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    if (i == 0) begin : g_first
      assign l_lt    = 1'b1;
      assign l_key   = '0;
      assign l_value = '0;
    end else begin : g_mid_l
      assign l_lt    = cell_lt[i-1];
      assign l_key   = cell_key[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key   = cell_key[i];
      assign r_value = cell_value[i];
    end else begin : g_mid_r
      assign r_key   = cell_key[i+1];
      assign r_value = cell_value[i+1];
    end

    skvt_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count),
      .req_key     (op_key),
      .req_value   (op_value),
      .left_lt     (l_lt),
      .left_key    (l_key),
      .left_value  (l_value),
      .right_key   (r_key),
      .right_value (r_value),
      .key         (cell_key[i]),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i]),
      .hit_value   (cell_hit[i])
    );
  end

  // match gather
  skvt_reduce #(
    .CAPACITY (CAPACITY)
  ) u_reduce (
    .clk         (clk),
    .eq          (cell_eq),
    .hit         (cell_hit),
    .found       (found),
    .found_value (found_value)
  );

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> (state == S_CMP))
    else $error("accepted request did not start a compare");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_APPLY))
    else $error("result raised outside the final step");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (apply && status_c == ST_FULL) |=> (count == CW'(CAPACITY)))
    else $error("count moved on a full insert");

endmodule

`default_nettype wire
